// ===== src/cpd_pkg.sv =====
// Shared types, constants and the CRC byte update for the packet deframer.
`timescale 1ns / 1ps
package cpd_pkg;

   localparam int unsigned PosWidth = 17;

   localparam logic [PosWidth-1:0] POS_MAX = {PosWidth{1'b1}};
   localparam logic [PosWidth-1:0] HDR_LEN = PosWidth'(4);
   localparam logic [PosWidth-1:0] CRC_LEN = PosWidth'(4);

   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam logic [2:0] TYPE_DATA = 3'd1;
   localparam logic [2:0] TYPE_ACK  = 3'd2;
   localparam logic [2:0] TYPE_NACK = 3'd4;

   typedef enum logic [2:0] {
      STATUS_OK           = 3'd0,
      STATUS_NO_HEADER    = 3'd1,
      STATUS_BAD_TYPE     = 3'd2,
      STATUS_CRC_MISMATCH = 3'd3,
      STATUS_TRUNCATED    = 3'd4
   } status_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
      logic       end_of_data;
   } item_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      status_type  frame_status;
      logic [2:0]  ptype;
      logic [4:0]  window;
      logic [7:0]  seqnum;
      logic [15:0] payload_length;
      logic [31:0] received_crc;
   } result_type;

   // Reflected CRC-32, one byte per call, eight bit steps.
   function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
      logic [31:0] c;
      c = c_in ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

   function automatic logic type_ok(input logic [2:0] t);
      return (t == TYPE_DATA) || (t == TYPE_ACK) || (t == TYPE_NACK);
   endfunction

endpackage

// ===== src/cpd_input_reg.sv =====
// Input register stage of the packet deframer: holds one item and drives req_stall.
`timescale 1ns / 1ps
module cpd_input_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_rx_byte,
   input  logic              req_end_of_data,
   input  logic              take,
   output cpd_pkg::item_type item
);

   cpd_pkg::item_type item_ff;
   cpd_pkg::item_type item_in;
   logic              accept;

   // Hold while the held item cannot move on.
   assign req_stall = item_ff.valid && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      item_in = item_ff;
      if (accept) begin
         item_in.valid       = 1'b1;
         item_in.rx_byte     = req_rx_byte;
         item_in.end_of_data = req_end_of_data;
      end else if (take) begin
         item_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_ff.valid       <= 1'b0;
         item_ff.rx_byte     <= item_in.rx_byte;
         item_ff.end_of_data <= item_in.end_of_data;
      end else begin
         item_ff <= item_in;
      end
   end

   assign item = item_ff;

endmodule

// ===== src/cpd_frame_core.sv =====
// Frame state, CRC accumulation and result formation of the packet deframer.
`timescale 1ns / 1ps
module cpd_frame_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  cpd_pkg::item_type   item,
   output logic                res_valid,
   output cpd_pkg::result_type res
);

   logic [cpd_pkg::PosWidth-1:0] pos_ff, pos_in;
   logic [2:0]  type_ff, type_in;
   logic [4:0]  window_ff, window_in;
   logic [7:0]  seqnum_ff, seqnum_in;
   logic [15:0] length_ff, length_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] carried_ff, carried_in;

   always_comb begin
      logic [7:0]                   b;
      logic [1:0]                   pad;
      logic [cpd_pkg::PosWidth-1:0] body_end;
      logic [cpd_pkg::PosWidth-1:0] count;
      logic [2:0]                   t_n;
      logic [4:0]                   w_n;
      logic [7:0]                   s_n;
      logic [15:0]                  l_n;
      logic [31:0]                  c_n;
      logic [31:0]                  k_n;
      logic                         pay;

      b   = item.rx_byte;
      t_n = type_ff;
      w_n = window_ff;
      s_n = seqnum_ff;
      l_n = length_ff;
      c_n = crc_ff;
      k_n = carried_ff;
      pay = 1'b0;

      pad      = 2'd0 - length_ff[1:0];
      body_end = cpd_pkg::HDR_LEN + {1'b0, length_ff}
                 + {{(cpd_pkg::PosWidth-2){1'b0}}, pad};

      if (pos_ff < cpd_pkg::HDR_LEN) begin
         case (pos_ff[1:0])
            2'd0: begin
               t_n = b[7:5];
               w_n = b[4:0];
            end
            2'd1: s_n = b;
            2'd2: l_n = {b, 8'd0};
            2'd3: l_n = {length_ff[15:8], b};
            default: l_n = length_ff;
         endcase
         c_n = cpd_pkg::crc_byte(crc_ff, b);
      end else if (pos_ff < body_end) begin
         c_n = cpd_pkg::crc_byte(crc_ff, b);
         pay = (pos_ff < cpd_pkg::HDR_LEN + {1'b0, length_ff}) && cpd_pkg::type_ok(type_ff);
      end else if (pos_ff < body_end + cpd_pkg::CRC_LEN) begin
         k_n = {carried_ff[23:0], b};
      end

      count = (pos_ff == cpd_pkg::POS_MAX) ? pos_ff : pos_ff + 1'b1;

      // Recompute the frame end from the length as it stands after this byte.
      pad      = 2'd0 - l_n[1:0];
      body_end = cpd_pkg::HDR_LEN + {1'b0, l_n} + {{(cpd_pkg::PosWidth-2){1'b0}}, pad};

      res.kind           = cpd_pkg::KIND_PAYLOAD;
      res.payload_byte   = b;
      res.frame_status   = cpd_pkg::STATUS_OK;
      res.ptype          = t_n;
      res.window         = w_n;
      res.seqnum         = s_n;
      res.payload_length = l_n;
      res.received_crc   = 32'd0;

      if (item.end_of_data) begin
         res.kind         = cpd_pkg::KIND_STATUS;
         res.payload_byte = 8'd0;
         if (count < cpd_pkg::HDR_LEN) begin
            res.frame_status   = cpd_pkg::STATUS_NO_HEADER;
            res.ptype          = 3'd0;
            res.window         = 5'd0;
            res.seqnum         = 8'd0;
            res.payload_length = 16'd0;
         end else if (!cpd_pkg::type_ok(t_n)) begin
            res.frame_status = cpd_pkg::STATUS_BAD_TYPE;
         end else if (count < body_end + cpd_pkg::CRC_LEN) begin
            res.frame_status = cpd_pkg::STATUS_TRUNCATED;
         end else begin
            res.received_crc = k_n;
            res.frame_status = ((c_n ^ cpd_pkg::CRC_INIT) == k_n) ?
                               cpd_pkg::STATUS_OK : cpd_pkg::STATUS_CRC_MISMATCH;
         end
      end

      res_valid = item.end_of_data || pay;

      // Clear for the next packet after its last byte.
      if (item.end_of_data) begin
         pos_in     = '0;
         type_in    = 3'd0;
         window_in  = 5'd0;
         seqnum_in  = 8'd0;
         length_in  = 16'd0;
         crc_in     = cpd_pkg::CRC_INIT;
         carried_in = 32'd0;
      end else begin
         pos_in     = count;
         type_in    = t_n;
         window_in  = w_n;
         seqnum_in  = s_n;
         length_in  = l_n;
         crc_in     = c_n;
         carried_in = k_n;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         type_ff    <= 3'd0;
         window_ff  <= 5'd0;
         seqnum_ff  <= 8'd0;
         length_ff  <= 16'd0;
         crc_ff     <= cpd_pkg::CRC_INIT;
         carried_ff <= 32'd0;
      end else if (take) begin
         pos_ff     <= pos_in;
         type_ff    <= type_in;
         window_ff  <= window_in;
         seqnum_ff  <= seqnum_in;
         length_ff  <= length_in;
         crc_ff     <= crc_in;
         carried_ff <= carried_in;
      end
   end

endmodule

// ===== src/crc32_packet_deframer_unit.sv =====
// Top level of the CRC-32 checked packet deframer.
//
// Usage: feed a packet one byte per item on the req_ channel (req_rx_byte),
// raising req_end_of_data on its last byte. Byte 0 holds type and window,
// byte 1 the sequence number, bytes 2..3 the big-endian payload length, then
// payload, zero padding to a multiple of four and a big-endian CRC-32.
// Each payload byte of a good-type packet, unless it is the last byte, comes out on the
// rsp_ channel with rsp_kind = 0; the last byte gives one status item with rsp_kind = 1.
// An accepted item passes through the input register, then the result register, before
// its result shows on rsp_; a new item can enter as the held one moves on.
// Throughput: one byte per cycle while rsp_stall does not hold the result; the
// byte-wide CRC update sits between the input register and the result register.
// Reset clears the frame state, loads the CRC with all ones and empties both
// registers. When the receiver raises rsp_stall the result is held and
// req_stall rises as soon as the input register is also occupied.
`timescale 1ns / 1ps
module crc32_packet_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [2:0]  rsp_frame_status,
   output logic [2:0]  rsp_ptype,
   output logic [4:0]  rsp_window,
   output logic [7:0]  rsp_seqnum,
   output logic [15:0] rsp_payload_length,
   output logic [31:0] rsp_received_crc
);

   cpd_pkg::item_type   item;
   cpd_pkg::result_type res;
   cpd_pkg::result_type res_ff;
   logic                res_valid;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                take;

   // Advance the held item once the result register is free or being drained.
   assign take = item.valid && (!rsp_valid_ff || !rsp_stall);

   cpd_input_reg u_input_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .req_end_of_data (req_end_of_data),
      .take            (take),
      .item            (item)
   );

   cpd_frame_core u_frame_core (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && res_valid) begin
         res_ff <= res;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = res_ff.kind;
   assign rsp_payload_byte   = res_ff.payload_byte;
   assign rsp_frame_status   = res_ff.frame_status;
   assign rsp_ptype          = res_ff.ptype;
   assign rsp_window         = res_ff.window;
   assign rsp_seqnum         = res_ff.seqnum;
   assign rsp_payload_length = res_ff.payload_length;
   assign rsp_received_crc   = res_ff.received_crc;

`ifndef NO_ASSERTIONS
   // Payload items only come from packets of a good type and carry no CRC or status.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == cpd_pkg::KIND_PAYLOAD) |->
         (cpd_pkg::type_ok(rsp_ptype) && rsp_received_crc == 32'd0
          && rsp_frame_status == cpd_pkg::STATUS_OK))
      else $error("payload item with bad type, status or crc");

   // A missing header reports no decoded fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == cpd_pkg::KIND_STATUS
       && rsp_frame_status == cpd_pkg::STATUS_NO_HEADER) |->
         (rsp_ptype == 3'd0 && rsp_payload_length == 16'd0 && rsp_received_crc == 32'd0))
      else $error("no-header status with decoded fields");

   // A result held under stall must not be overwritten.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(res_ff)))
      else $error("held result changed");

   // The input side stalls only with an occupied input register.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (item.valid && rsp_valid_ff && rsp_stall))
      else $error("input stalled without cause");
`endif

endmodule

// ===== sim/crc32_packet_deframer_checker.sv =====
// Checker for the packet deframer: byte-level frame predictor and result comparison.
`timescale 1ns / 1ps
package crc32_deframer_tb_pkg;

   // Reflected CRC-32 register update, one data bit at a time from the lsb.
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      logic        fb;
      c = crc;
      for (int k = 0; k < 8; k++) begin
         fb = c[0] ^ data[k];
         c  = {1'b0, c[31:1]} ^ (fb ? cpd_pkg::CRC_POLY : 32'h0);
      end
      return c;
   endfunction

endpackage

module crc32_packet_deframer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        req_end_of_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic [2:0]  rsp_frame_status,
   input  logic [2:0]  rsp_ptype,
   input  logic [4:0]  rsp_window,
   input  logic [7:0]  rsp_seqnum,
   input  logic [15:0] rsp_payload_length,
   input  logic [31:0] rsp_received_crc,
   output int          fail_count,
   output int          pending,
   output int          payload_seen,
   output int          status_seen,
   output int          good_crc_seen
);

   localparam int MaxReports = 20;

   // Frame state of the predictor.
   logic [cpd_pkg::PosWidth-1:0] frame_pos;
   logic [2:0]                   frame_ptype;
   logic [4:0]                   frame_window;
   logic [7:0]                   frame_seqnum;
   logic [15:0]                  frame_length;
   logic [31:0]                  frame_crc;
   logic [31:0]                  trailer_crc;

   cpd_pkg::result_type expected_results[$];

   initial begin
      fail_count    = 0;
      pending       = 0;
      payload_seen  = 0;
      status_seen   = 0;
      good_crc_seen = 0;
   end

   function automatic logic type_accepted(input logic [2:0] t);
      return (t == cpd_pkg::TYPE_DATA) || (t == cpd_pkg::TYPE_ACK)
             || (t == cpd_pkg::TYPE_NACK);
   endfunction

   function automatic string result_text(input cpd_pkg::result_type r);
      return $sformatf("kind=%0d byte=%02h status=%0d type=%0d win=%0d seq=%0d len=%0d crc=%08h",
                       r.kind, r.payload_byte, r.frame_status, r.ptype, r.window, r.seqnum,
                       r.payload_length, r.received_crc);
   endfunction

   task automatic clear_frame_state();
      frame_pos    = '0;
      frame_ptype  = '0;
      frame_window = '0;
      frame_seqnum = '0;
      frame_length = '0;
      frame_crc    = cpd_pkg::CRC_INIT;
      trailer_crc  = '0;
   endtask

   task automatic predict_frame_byte(input logic [7:0] b, input logic last);
      int unsigned         pos, pad, body_end, count;
      logic                emit;
      cpd_pkg::result_type r;
      pos  = frame_pos;
      emit = 1'b0;
      if (pos < cpd_pkg::HDR_LEN) begin
         case (pos)
            0: begin
               frame_ptype  = b[7:5];
               frame_window = b[4:0];
            end
            1: frame_seqnum = b;
            2: frame_length = {b, 8'h00};
            default: frame_length = {frame_length[15:8], b};
         endcase
         frame_crc = crc32_deframer_tb_pkg::crc32_step(frame_crc, b);
      end else begin
         pad      = (4 - frame_length[1:0]) & 3;
         body_end = cpd_pkg::HDR_LEN + frame_length + pad;
         if (pos < body_end) begin
            frame_crc = crc32_deframer_tb_pkg::crc32_step(frame_crc, b);
            emit = (pos < cpd_pkg::HDR_LEN + frame_length) && type_accepted(frame_ptype);
         end else if (pos < body_end + cpd_pkg::CRC_LEN) begin
            trailer_crc = {trailer_crc[23:0], b};
         end
         // later bytes up to the end flag are dropped
      end
      if (frame_pos != cpd_pkg::POS_MAX) frame_pos = frame_pos + 1'b1;
      count = frame_pos;

      r = '0;
      if (last) begin
         pad      = (4 - frame_length[1:0]) & 3;
         body_end = cpd_pkg::HDR_LEN + frame_length + pad;
         r.kind   = cpd_pkg::KIND_STATUS;
         if (count < cpd_pkg::HDR_LEN) begin
            r.frame_status = cpd_pkg::STATUS_NO_HEADER;
         end else begin
            r.ptype          = frame_ptype;
            r.window         = frame_window;
            r.seqnum         = frame_seqnum;
            r.payload_length = frame_length;
            if (!type_accepted(frame_ptype)) begin
               r.frame_status = cpd_pkg::STATUS_BAD_TYPE;
            end else if (count < body_end + cpd_pkg::CRC_LEN) begin
               r.frame_status = cpd_pkg::STATUS_TRUNCATED;
            end else begin
               r.received_crc = trailer_crc;
               r.frame_status = (~frame_crc == trailer_crc) ?
                                cpd_pkg::STATUS_OK : cpd_pkg::STATUS_CRC_MISMATCH;
            end
         end
         expected_results.push_back(r);
         clear_frame_state();
      end else if (emit) begin
         r.kind           = cpd_pkg::KIND_PAYLOAD;
         r.payload_byte   = b;
         r.ptype          = frame_ptype;
         r.window         = frame_window;
         r.seqnum         = frame_seqnum;
         r.payload_length = frame_length;
         expected_results.push_back(r);
      end
   endtask

   always @(posedge clock) begin
      cpd_pkg::result_type got, want;
      int                  errs;
      errs = 0;
      if (reset) begin
         clear_frame_state();
         expected_results.delete();
      end else begin
         // compare first: nothing accepted at this edge can show up at the same edge
         if (rsp_valid && !rsp_stall) begin
            got.kind           = rsp_kind;
            got.payload_byte   = rsp_payload_byte;
            got.frame_status   = cpd_pkg::status_type'(rsp_frame_status);
            got.ptype          = rsp_ptype;
            got.window         = rsp_window;
            got.seqnum         = rsp_seqnum;
            got.payload_length = rsp_payload_length;
            got.received_crc   = rsp_received_crc;
            if (expected_results.size() == 0) begin
               errs = 1;
               if (fail_count < MaxReports)
                  $display("%0t: result with nothing expected: expected none, actual %s",
                           $time, result_text(got));
            end else begin
               want = expected_results.pop_front();
               if (got !== want) begin
                  errs = 1;
                  if (fail_count < MaxReports)
                     $display("%0t: result mismatch\n   expected %s\n   actual   %s",
                              $time, result_text(want), result_text(got));
               end
               if (want.kind == cpd_pkg::KIND_STATUS) begin
                  status_seen <= status_seen + 1;
                  if (want.frame_status == cpd_pkg::STATUS_OK)
                     good_crc_seen <= good_crc_seen + 1;
               end else begin
                  payload_seen <= payload_seen + 1;
               end
            end
         end
         if (req_valid && !req_stall) predict_frame_byte(req_rx_byte, req_end_of_data);
      end
      fail_count <= fail_count + errs;
      pending    <= expected_results.size();
   end

endmodule

// ===== sim/tb_crc32_packet_deframer_unit.sv =====
// Testbench top for the packet deframer: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module tb_crc32_packet_deframer_unit;

   localparam int ItemTarget     = 1250;
   localparam int CalmFrom       = 1100;
   localparam int PressureAt     = 400;
   localparam int HoldOffCycles  = 80;
   localparam int CycleLimit     = 400000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_rx_byte;
   logic        req_end_of_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic [2:0]  rsp_frame_status;
   logic [2:0]  rsp_ptype;
   logic [4:0]  rsp_window;
   logic [7:0]  rsp_seqnum;
   logic [15:0] rsp_payload_length;
   logic [31:0] rsp_received_crc;

   int fail_count, pending, payload_seen, status_seen, good_crc_seen;

   int   cycle_count = 0;
   int   sent_items = 0;
   int   trailing_sent = 0;
   int   sender_idle_pct = 0;
   logic calm;
   logic hold_off_go;

   logic [7:0] frame_q[$];

   crc32_packet_deframer_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_data    (req_end_of_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_ptype          (rsp_ptype),
      .rsp_window         (rsp_window),
      .rsp_seqnum         (rsp_seqnum),
      .rsp_payload_length (rsp_payload_length),
      .rsp_received_crc   (rsp_received_crc)
   );

   crc32_packet_deframer_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_rx_byte        (req_rx_byte),
      .req_end_of_data    (req_end_of_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_ptype          (rsp_ptype),
      .rsp_window         (rsp_window),
      .rsp_seqnum         (rsp_seqnum),
      .rsp_payload_length (rsp_payload_length),
      .rsp_received_crc   (rsp_received_crc),
      .fail_count         (fail_count),
      .pending            (pending),
      .payload_seen       (payload_seen),
      .status_seen        (status_seen),
      .good_crc_seen      (good_crc_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
         $display("tb_crc32_packet_deframer_unit NOT OK");
         $finish;
      end
   end

   // Offer one item, with an optional idle burst ahead of it; return once it is taken.
   task automatic push_byte(input logic [7:0] b, input logic last);
      if (!calm && $urandom_range(0, 99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rx_byte     <= b;
      req_end_of_data <= last;
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_frame(input int trailing);
      foreach (frame_q[i]) push_byte(frame_q[i], i == frame_q.size() - 1);
      trailing_sent += trailing;
   endtask

   task automatic add_header(input logic [2:0] ptype, input logic [15:0] len);
      frame_q.delete();
      frame_q.push_back({ptype, 5'($urandom)});
      frame_q.push_back(8'($urandom));
      frame_q.push_back(len[15:8]);
      frame_q.push_back(len[7:0]);
   endtask

   // Complete frame: header, payload, padding and trailing CRC.
   task automatic build_frame(input logic [2:0] ptype, input int len, input bit dirty_pad,
                              input bit bad_crc);
      logic [31:0] crc;
      int          pad;
      add_header(ptype, 16'(len));
      repeat (len) frame_q.push_back(8'($urandom));
      pad = (4 - len % 4) % 4;
      repeat (pad) frame_q.push_back(dirty_pad ? 8'($urandom) : 8'h00);
      crc = cpd_pkg::CRC_INIT;
      foreach (frame_q[i]) crc = crc32_deframer_tb_pkg::crc32_step(crc, frame_q[i]);
      crc = ~crc;
      if (bad_crc) crc ^= 32'h1 << $urandom_range(0, 31);
      for (int k = 3; k >= 0; k--) frame_q.push_back(crc[8*k +: 8]);
   endtask

   function automatic logic [2:0] good_type();
      case ($urandom_range(0, 2))
         0: return cpd_pkg::TYPE_DATA;
         1: return cpd_pkg::TYPE_ACK;
         default: return cpd_pkg::TYPE_NACK;
      endcase
   endfunction

   task automatic send_random_frame();
      int          pick, len, pad, body_end, cut, trailing;
      logic [2:0]  t;
      logic [15:0] hdr_len;
      pick     = $urandom_range(0, 99);
      trailing = 0;
      if (pick < 62) begin
         len = ($urandom_range(0, 19) == 0) ? $urandom_range(21, 160) : $urandom_range(0, 20);
         build_frame(good_type(), len, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
         if ($urandom_range(0, 9) == 0) trailing = $urandom_range(1, 3);
         repeat (trailing) frame_q.push_back(8'($urandom));
      end else if (pick < 72) begin
         do t = 3'($urandom);
         while (t == cpd_pkg::TYPE_DATA || t == cpd_pkg::TYPE_ACK
                || t == cpd_pkg::TYPE_NACK);
         build_frame(t, $urandom_range(0, 12), 1'b0, 1'b0);
         if ($urandom_range(0, 1) == 0)
            while (frame_q.size() > cpd_pkg::HDR_LEN && $urandom_range(0, 3) != 0)
               void'(frame_q.pop_back());
      end else if (pick < 84) begin
         // header followed by less than the full body and CRC
         hdr_len = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
         if ($urandom_range(0, 7) == 0) hdr_len = 16'hFFFF;
         add_header(good_type(), hdr_len);
         pad      = (4 - hdr_len % 4) % 4;
         body_end = cpd_pkg::HDR_LEN + hdr_len + pad;
         cut      = $urandom_range(cpd_pkg::HDR_LEN, (body_end + 3 < 64) ? body_end + 3 : 64);
         while (frame_q.size() < cut) frame_q.push_back(8'($urandom));
      end else begin
         frame_q.delete();
         repeat ((pick < 92) ? $urandom_range(1, 3) : $urandom_range(1, 24))
            frame_q.push_back(8'($urandom));
      end
      send_frame(trailing);
   endtask

   // Receiver: random stall bursts, one long hold-off on request, nothing at the end.
   initial begin
      int  rsp_stall_pct;
      bit  hold_off_done;
      rsp_stall_pct = 0;
      hold_off_done = 0;
      rsp_stall <= 1'b0;
      repeat (4) @(posedge clock);
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) begin
            case ($urandom_range(0, 3))
               0: rsp_stall_pct = 0;
               1: rsp_stall_pct = 3;
               2: rsp_stall_pct = 10;
               default: rsp_stall_pct = 30;
            endcase
         end
         if (hold_off_go && !hold_off_done) begin
            hold_off_done = 1;
            rsp_stall <= 1'b1;
            repeat (HoldOffCycles) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < rsp_stall_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      bit pressure_done;
      pressure_done = 0;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_rx_byte     <= 8'h00;
      req_end_of_data <= 1'b0;
      calm            <= 1'b0;
      hold_off_go     <= 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // too short for a header
      frame_q = '{8'hFF};
      send_frame(0);
      // type 7, window 31, length 65535: rejected type
      frame_q = '{8'hFF, 8'h00, 8'hFF, 8'hFF};
      send_frame(0);
      // empty good frame with one byte after the CRC
      build_frame(cpd_pkg::TYPE_NACK, 0, 1'b0, 1'b0);
      frame_q.push_back(8'h00);
      send_frame(1);
      build_frame(cpd_pkg::TYPE_DATA, 0, 1'b0, 1'b1);
      send_frame(0);
      // ends on a payload byte: the status replaces it
      frame_q = '{{cpd_pkg::TYPE_ACK, 5'h15}, 8'h80, 8'h00, 8'h02, 8'h7E};
      send_frame(0);

      while (sent_items - trailing_sent < ItemTarget) begin
         if (sent_items >= CalmFrom) calm <= 1'b1;
         if (!pressure_done && sent_items >= PressureAt) begin
            // receiver holds off while a long frame streams in
            pressure_done   = 1;
            sender_idle_pct = 0;
            hold_off_go <= 1'b1;
            build_frame(cpd_pkg::TYPE_DATA, 48, 1'b0, 1'b0);
            send_frame(0);
         end
         case ($urandom_range(0, 3))
            0: sender_idle_pct = 0;
            1: sender_idle_pct = 5;
            2: sender_idle_pct = 20;
            default: sender_idle_pct = 50;
         endcase
         send_random_frame();
      end
      req_valid <= 1'b0;

      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run covered %0d input bytes; %0d payload results and %0d frame statuses checked",
               sent_items, payload_seen, status_seen);
      $display("%0d frames passed their CRC; receiver held off for %0d cycles once",
               good_crc_seen, HoldOffCycles);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_crc32_packet_deframer_unit OK");
      end else begin
         $display("%0d mismatches, %0d expected results never arrived", fail_count, pending);
         $display("tb_crc32_packet_deframer_unit NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/cpd_pkg.sv
src/cpd_input_reg.sv
src/cpd_frame_core.sv
src/crc32_packet_deframer_unit.sv
sim/crc32_packet_deframer_checker.sv
sim/tb_crc32_packet_deframer_unit.sv
